// ===== design/anc2038_pkg.sv =====
// Shared types, constants and helpers for the ST 436 to ST 2038 ancillary converter.
// No dependencies; the front, queue, back and top design files import this package.
`default_nettype none

package anc2038_pkg;

	// Default depth of the token queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 16;

	// Bit widths used by the unpacker and the packer.
	localparam int WORD_BITS = 10;
	localparam int BYTE_BITS = 8;
	localparam int SKIP_BITS = 2;
	localparam int BUF_BITS  = 17;   // 9 leftover bits plus one new byte
	localparam int CNT_BITS  = 5;
	localparam int VAL_BITS  = 12;   // widest chunk: horizontal offset
	localparam int NB_BITS   = 4;
	localparam int ACC_BITS  = 19;   // 7 leftover bits plus the widest chunk

	localparam logic [11:0] HORIZ_OFFSET = 12'hFFF;
	localparam logic [8:0]  SUM_MASK     = 9'h1FF;
	localparam logic [7:0]  PAD_ONES     = 8'hFF;

	// Sample coding codes.
	localparam logic [7:0] CODING_5  = 8'd5;
	localparam logic [7:0] CODING_7  = 8'd7;
	localparam logic [7:0] CODING_8  = 8'd8;
	localparam logic [7:0] CODING_9  = 8'd9;
	localparam logic [7:0] CODING_11 = 8'd11;

	// Result status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_HDR_SHORT = 2'd1;
	localparam logic [1:0] STAT_COUNT_BIG = 2'd2;
	localparam logic [1:0] STAT_TRUNC     = 2'd3;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [10:0] line_number;
		logic [15:0] sample_count;
		logic [7:0]  sample_coding;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic [1:0] status;
	} out_item_t;

	// One unit of work for the bit packer.
	typedef struct packed {
		logic                err;     // error result, no stream bits
		logic [1:0]          status;
		logic                start;   // first chunk of a packet: drop stale bits
		logic                fin;     // pad to byte boundary after this chunk
		logic [NB_BITS-1:0]  nbits;
		logic [VAL_BITS-1:0] val;
	} tok_t;

	// b8 even parity, b9 its inverse.
	function automatic logic [9:0] with_par(input logic [7:0] b);
		logic p;
		p = ^b;
		return {~p, p, b};
	endfunction

	function automatic tok_t mk_bits(input logic [NB_BITS-1:0] n, input logic [VAL_BITS-1:0] v,
			input logic start, input logic fin);
		tok_t t;
		t.err    = 1'b0;
		t.status = STAT_OK;
		t.start  = start;
		t.fin    = fin;
		t.nbits  = n;
		t.val    = v;
		return t;
	endfunction

	function automatic tok_t mk_err(input logic [1:0] st);
		tok_t t;
		t.err    = 1'b1;
		t.status = st;
		t.start  = 1'b0;
		t.fin    = 1'b0;
		t.nbits  = '0;
		t.val    = '0;
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== design/anc2038_chan_if.sv =====
// Valid/ready channel carrying one request of a given payload type.
// Payload types come from anc2038_pkg at the point of instantiation.
`default_nettype none

interface anc2038_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/anc2038_front.sv =====
// Front end: takes payload bytes, unpacks 8/10-bit words, parses the header
// and issues packer tokens. Uses anc2038_pkg and anc2038_chan_if.
`default_nettype none

module anc2038_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	anc2038_chan_if.sink      anc,
	output anc2038_pkg::tok_t push_tok,
	output logic              push,
	input  wire logic         room
);
	import anc2038_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_DATA, PH_DONE} phase_t;
	typedef enum logic [2:0] {HS_FLAGS, HS_LINE, HS_HOFF, HS_DID, HS_SDID, HS_COUNT} hdr_step_t;

	phase_t               phase_q, phase_d;
	hdr_step_t            hseq_q, hseq_d;
	logic                 hseq_busy_q, hseq_busy_d;
	logic                 ck_pend_q, ck_pend_d;
	logic                 last_pend_q, last_pend_d;
	logic                 ten_q, ten_d;
	logic                 chroma_q, chroma_d;
	logic [10:0]          line_q, line_d;
	logic [15:0]          samples_q, samples_d;
	logic [BUF_BITS-1:0]  buf_q, buf_d;
	logic [CNT_BITS-1:0]  cnt_q, cnt_d;
	logic [1:0]           hidx_q, hidx_d;
	logic [9:0]           did_q, did_d, sdid_q, sdid_d, count_q, count_d;
	logic [9:0]           words_q, words_d;
	logic [1:0]           grp_q, grp_d;
	logic [8:0]           sum_q, sum_d;

	logic                 active, enough, step_avail;
	logic [CNT_BITS-1:0]  need, rem;
	logic [BUF_BITS-1:0]  shifted, buf_keep;
	logic [9:0]           word;
	logic [9:0]           cur_coded;
	logic [7:0]           coding;

	function automatic logic [9:0] coded(input logic ten, input logic [9:0] w);
		return ten ? w : with_par(w[7:0]);
	endfunction

	assign active = (phase_q == PH_HEADER) || (phase_q == PH_DATA);

	always_comb begin
		if (phase_q == PH_HEADER) begin
			if (hidx_q == 2'd3)
				need = ten_q ? CNT_BITS'(SKIP_BITS) : '0;
			else
				need = ten_q ? CNT_BITS'(WORD_BITS) : CNT_BITS'(BYTE_BITS);
		end else if (ten_q && grp_q == 2'd3) begin
			need = CNT_BITS'(SKIP_BITS);
		end else begin
			need = ten_q ? CNT_BITS'(WORD_BITS) : CNT_BITS'(BYTE_BITS);
		end
	end

	assign enough     = cnt_q >= need;
	assign rem        = cnt_q - need;
	assign shifted    = buf_q >> rem;
	assign word       = shifted[9:0] & ~(10'h3FF << need);
	assign buf_keep   = buf_q & ~({BUF_BITS{1'b1}} << rem);
	assign cur_coded  = coded(ten_q, word);
	assign step_avail = ck_pend_q || hseq_busy_q || (active && (enough || last_pend_q));
	assign anc.ready  = !step_avail;
	assign coding     = anc.data.sample_coding;

	always_comb begin
		phase_d     = phase_q;
		hseq_d      = hseq_q;
		hseq_busy_d = hseq_busy_q;
		ck_pend_d   = ck_pend_q;
		last_pend_d = last_pend_q;
		ten_d       = ten_q;
		chroma_d    = chroma_q;
		line_d      = line_q;
		samples_d   = samples_q;
		buf_d       = buf_q;
		cnt_d       = cnt_q;
		hidx_d      = hidx_q;
		did_d       = did_q;
		sdid_d      = sdid_q;
		count_d     = count_q;
		words_d     = words_q;
		grp_d       = grp_q;
		sum_d       = sum_q;
		push        = 1'b0;
		push_tok    = mk_err(STAT_OK);

		if (ck_pend_q) begin
			// checksum word, then pad and close the packet
			if (room) begin
				push      = 1'b1;
				push_tok  = mk_bits(NB_BITS'(WORD_BITS),
					ten_q ? VAL_BITS'(sum_q) : VAL_BITS'(with_par(sum_q[7:0])), 1'b0, 1'b1);
				ck_pend_d = 1'b0;
			end
		end else if (hseq_busy_q) begin
			if (room) begin
				push = 1'b1;
				unique case (hseq_q)
					HS_FLAGS: push_tok = mk_bits(NB_BITS'(7), VAL_BITS'(chroma_q), 1'b1, 1'b0);
					HS_LINE:  push_tok = mk_bits(NB_BITS'(11), VAL_BITS'(line_q), 1'b0, 1'b0);
					HS_HOFF:  push_tok = mk_bits(NB_BITS'(12), HORIZ_OFFSET, 1'b0, 1'b0);
					HS_DID:   push_tok = mk_bits(NB_BITS'(WORD_BITS),
						VAL_BITS'(coded(ten_q, did_q)), 1'b0, 1'b0);
					HS_SDID:  push_tok = mk_bits(NB_BITS'(WORD_BITS),
						VAL_BITS'(coded(ten_q, sdid_q)), 1'b0, 1'b0);
					HS_COUNT: push_tok = mk_bits(NB_BITS'(WORD_BITS),
						VAL_BITS'(coded(ten_q, count_q)), 1'b0, 1'b0);
					default:  push_tok = mk_bits(NB_BITS'(7), VAL_BITS'(chroma_q), 1'b1, 1'b0);
				endcase
				hseq_d = hdr_step_t'(hseq_q + 3'd1);
				if (hseq_q == HS_COUNT) begin
					hseq_busy_d = 1'b0;
					ck_pend_d   = (count_q == '0);
				end
			end
		end else if (active && enough) begin
			if (room) begin
				cnt_d = rem;
				buf_d = buf_keep;
				if (phase_q == PH_HEADER) begin
					if (hidx_q != 2'd3) begin
						unique case (hidx_q)
							2'd0:    did_d   = word;
							2'd1:    sdid_d  = word;
							default: count_d = word;
						endcase
						hidx_d = hidx_q + 2'd1;
					end else if ({1'b0, samples_q} < (17'(count_q) + 17'd3)) begin
						push     = 1'b1;
						push_tok = mk_err(STAT_COUNT_BIG);
						phase_d  = PH_DONE;
					end else begin
						hseq_busy_d = 1'b1;
						hseq_d      = HS_FLAGS;
						sum_d       = (did_q[8:0] + sdid_q[8:0] + count_q[8:0]) & SUM_MASK;
						words_d     = '0;
						grp_d       = '0;
						phase_d     = (count_q == '0) ? PH_DONE : PH_DATA;
					end
				end else if (ten_q && grp_q == 2'd3) begin
					grp_d = '0;
				end else begin
					grp_d    = (grp_q == 2'd2) ? 2'd3 : grp_q + 2'd1;
					sum_d    = sum_q + word[8:0];
					push     = 1'b1;
					push_tok = mk_bits(NB_BITS'(WORD_BITS), VAL_BITS'(cur_coded), 1'b0, 1'b0);
					words_d  = words_q + 10'd1;
					if ((11'(words_q) + 11'd1) >= 11'(count_q)) begin
						phase_d   = PH_DONE;
						ck_pend_d = 1'b1;
					end
				end
			end
		end else if (active && last_pend_q) begin
			if (room) begin
				push        = 1'b1;
				push_tok    = mk_err((phase_q == PH_HEADER) ? STAT_HDR_SHORT : STAT_TRUNC);
				phase_d     = PH_DONE;
				last_pend_d = 1'b0;
			end
		end else if (anc.valid) begin
			last_pend_d = anc.data.last_byte;
			if (anc.data.first_byte) begin
				line_d    = anc.data.line_number;
				samples_d = anc.data.sample_count;
				ten_d     = (coding == CODING_7) || (coding == CODING_8) || (coding == CODING_9);
				chroma_d  = (coding == CODING_5) || (coding == CODING_8) || (coding == CODING_11);
				buf_d     = BUF_BITS'(anc.data.data_byte);
				cnt_d     = CNT_BITS'(BYTE_BITS);
				hidx_d    = '0;
				did_d     = '0;
				sdid_d    = '0;
				count_d   = '0;
				words_d   = '0;
				grp_d     = '0;
				sum_d     = '0;
				phase_d   = PH_HEADER;
			end else if (active) begin
				buf_d = {buf_q[BUF_BITS-BYTE_BITS-1:0], anc.data.data_byte};
				cnt_d = cnt_q + CNT_BITS'(BYTE_BITS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hseq_q      <= HS_FLAGS;
			hseq_busy_q <= 1'b0;
			ck_pend_q   <= 1'b0;
			last_pend_q <= 1'b0;
			ten_q       <= 1'b0;
			chroma_q    <= 1'b0;
			line_q      <= '0;
			samples_q   <= '0;
			buf_q       <= '0;
			cnt_q       <= '0;
			hidx_q      <= '0;
			did_q       <= '0;
			sdid_q      <= '0;
			count_q     <= '0;
			words_q     <= '0;
			grp_q       <= '0;
			sum_q       <= '0;
		end else begin
			phase_q     <= phase_d;
			hseq_q      <= hseq_d;
			hseq_busy_q <= hseq_busy_d;
			ck_pend_q   <= ck_pend_d;
			last_pend_q <= last_pend_d;
			ten_q       <= ten_d;
			chroma_q    <= chroma_d;
			line_q      <= line_d;
			samples_q   <= samples_d;
			buf_q       <= buf_d;
			cnt_q       <= cnt_d;
			hidx_q      <= hidx_d;
			did_q       <= did_d;
			sdid_q      <= sdid_d;
			count_q     <= count_d;
			words_q     <= words_d;
			grp_q       <= grp_d;
			sum_q       <= sum_d;
		end
	end

`ifndef SYNTHESIS
	// unpacker never holds more than a leftover word plus one byte
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(BUF_BITS))
		else $error("front: bit buffer overfilled");
	// a pending checksum always follows the close of the packet
	a_ck_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ck_pend_q) |-> phase_q == PH_DONE)
		else $error("front: checksum pending in an open packet");
`endif

endmodule

`default_nettype wire

// ===== design/anc2038_tokq.sv =====
// Token queue between front and back: RAM array with a registered head.
// Uses anc2038_pkg for the token type.
`default_nettype none

module anc2038_tokq #(
	parameter int DEPTH = anc2038_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire anc2038_pkg::tok_t  push_tok,
	output logic                    room,
	output logic                    head_valid,
	output anc2038_pkg::tok_t       head_tok,
	input  wire logic               pop
);
	import anc2038_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tok_t          mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] mem_cnt_q;
	logic          head_valid_q;
	tok_t          head_q;
	logic          load;

	assign room       = mem_cnt_q != CW'(DEPTH);
	assign load       = (mem_cnt_q != '0) && (!head_valid_q || pop);
	assign head_valid = head_valid_q;
	assign head_tok   = head_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_tok;
		if (load)
			head_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			mem_cnt_q    <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (load)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			mem_cnt_q <= mem_cnt_q + CW'(push) - CW'(load);
			if (load)
				head_valid_q <= 1'b1;
			else if (pop)
				head_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("tokq: write into a full queue");
	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid_q)
		else $error("tokq: pop with no head entry");
`endif

endmodule

`default_nettype wire

// ===== design/anc2038_back.sv =====
// Back end: bit packer that turns tokens into stream bytes, pads with ones
// and holds the output register. Uses anc2038_pkg and anc2038_chan_if.
`default_nettype none

module anc2038_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire anc2038_pkg::tok_t head_tok,
	output logic                   pop,
	anc2038_chan_if.source         st2038
);
	import anc2038_pkg::*;

	logic [ACC_BITS-1:0]          acc_q;
	logic [CNT_BITS-1:0]          bcnt_q;
	logic                         fin_q;
	logic                         out_valid_q;
	out_item_t                    out_q;

	logic                         out_free, emit, last, load_out;
	logic [ACC_BITS+BYTE_BITS-1:0] win;
	logic [ACC_BITS-1:0]          acc_base;
	logic [CNT_BITS-1:0]          cnt_base;

	assign out_free = !out_valid_q || st2038.ready;
	assign emit     = (bcnt_q >= CNT_BITS'(BYTE_BITS)) || (fin_q && bcnt_q != '0);
	// window of the 8 bits just below the fill point; ones come in below when padding
	assign win      = {acc_q, PAD_ONES} >> bcnt_q;
	assign last     = fin_q && (bcnt_q <= CNT_BITS'(BYTE_BITS));
	assign pop      = head_valid && !emit && (!head_tok.err || out_free);
	assign load_out = out_free && (emit || (head_valid && head_tok.err));
	assign acc_base = head_tok.start ? '0 : acc_q;
	assign cnt_base = head_tok.start ? '0 : bcnt_q;

	assign st2038.valid = out_valid_q;
	assign st2038.data  = out_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (emit) begin
				out_q.out_byte <= win[BYTE_BITS-1:0];
				out_q.out_last <= last;
				out_q.status   <= STAT_OK;
			end else begin
				out_q.out_byte <= '0;
				out_q.out_last <= 1'b1;
				out_q.status   <= head_tok.status;
			end
		end
		if (pop && !head_tok.err)
			acc_q <= (acc_base << head_tok.nbits) | ACC_BITS'(head_tok.val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q      <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (st2038.ready)
				out_valid_q <= 1'b0;

			if (emit && out_free) begin
				if (last) begin
					bcnt_q <= '0;
					fin_q  <= 1'b0;
				end else begin
					bcnt_q <= bcnt_q - CNT_BITS'(BYTE_BITS);
				end
			end else if (pop) begin
				if (head_tok.err) begin
					bcnt_q <= '0;
					fin_q  <= 1'b0;
				end else begin
					bcnt_q <= cnt_base + CNT_BITS'(head_tok.nbits);
					fin_q  <= head_tok.fin;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= CNT_BITS'(ACC_BITS))
		else $error("back: packer accumulator overfilled");
	a_fin_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> bcnt_q != '0)
		else $error("back: packet close pending with no bits left");
`endif

endmodule

`default_nettype wire

// ===== design/anc_436_to_2038_converter.sv =====
// Top level of the ST 436 to ST 2038 ancillary converter.
// Depends on anc2038_pkg, anc2038_chan_if, anc2038_front, anc2038_tokq, anc2038_back.
//
//  channel  | dir | payload                                                   | accepted when
//  ---------+-----+-----------------------------------------------------------+--------------
//  anc      | in  | data_byte, first_byte, last_byte, line, count, coding     | valid & ready
//  st2038   | out | out_byte, out_last, status                                | valid & ready
//
// Pace: the front takes a request only when no unpack step is left, then needs one
//   unpack step per word; in 10-bit mode a 2-bit skip in the byte takes a step of
//   its own. The header adds a step for each header token and the final word one
//   more for the checksum. The pace is set by the front's single unpack step per
//   cycle while the token queue has room. The back sends at most one stream byte per cycle.
// Reset: arst_n clears all control state; the token queue array is not cleared.
// Stalls: the token queue (OUT_QUEUE_DEPTH entries plus a registered head) lets front and back
//   stall independently; the output register takes a new byte as the last is accepted.
`default_nettype none

module anc_436_to_2038_converter #(
	parameter int OUT_QUEUE_DEPTH = anc2038_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	anc2038_chan_if.sink   anc,
	anc2038_chan_if.source st2038
);
	import anc2038_pkg::*;

	// front -> queue
	tok_t push_tok;
	logic push;
	logic room;

	// queue -> back
	tok_t head_tok;
	logic head_valid;
	logic pop;

	// Front: unpacks bytes into words, parses DID/SDID/count, checks the
	// sample count and issues packer tokens (header chunks, words,
	// checksum, error results).
	anc2038_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.anc      (anc),
		.push_tok (push_tok),
		.push     (push),
		.room     (room)
	);

	// Short queue decoupling the parser from the packer.
	anc2038_tokq #(
		.DEPTH (OUT_QUEUE_DEPTH)
	) u_tokq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_tok   (push_tok),
		.room       (room),
		.head_valid (head_valid),
		.head_tok   (head_tok),
		.pop        (pop)
	);

	// Back: packs token bits MSB first into bytes, pads the packet end
	// with ones and marks the final byte.
	anc2038_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_tok   (head_tok),
		.pop        (pop),
		.st2038     (st2038)
	);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for anc_436_to_2038_converter: payload-byte requests in, ST 2038 bytes out.
// Depends on anc2038_pkg and anc2038_chan_if; the expected stream comes from a predictor kept here.

module testbench;
	import anc2038_pkg::*;

	localparam int LONG_HOLD    = 200;  // sink stall long enough to back up the token queue
	localparam int DRAIN_CYCLES = 40;   // quiet tail after the last expected byte
	localparam int RANDOM_REQS  = 300;

	typedef enum logic [1:0] {P_IDLE, P_HEADER, P_DATA, P_DONE} pkt_phase_t;
	typedef enum {BY_PREDICTOR, NO_RESULT, ERROR_RESULT} row_check_t;

	typedef struct {
		in_item_t   req;
		row_check_t check;
		logic [1:0] status;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	anc2038_chan_if #(.payload_t(in_item_t))  anc_ch ();
	anc2038_chan_if #(.payload_t(out_item_t)) st_ch ();

	anc_436_to_2038_converter #(.OUT_QUEUE_DEPTH(QUEUE_DEPTH_DEF)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.anc    (anc_ch),
		.st2038 (st_ch)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor state: one packet in flight, bit-exact with the block.
	// ---------------------------------------------------------------
	bit          is_ten, chroma;
	logic [10:0] line_q;
	logic [15:0] samples_q;
	pkt_phase_t  ph = P_IDLE;
	logic [31:0] ibuf, obuf;
	int          icnt, ocnt;
	logic [1:0]  hdr_idx, grp;
	logic [9:0]  did_w, sdid_w, cnt_w, words_in;
	logic [8:0]  csum;

	out_item_t step_bytes [$];      // results of the request just accepted
	out_item_t pending_st2038 [$];  // expected bytes, oldest first
	bit        stream_bits [$];     // scratch for building 10-bit payloads

	int  errors, requests_sent, packets, ten_packets, bytes_ok;
	int  err_seen [4];
	bit  long_hold_due, calm;

	function automatic out_item_t mk_result(logic [7:0] b, logic l, logic [1:0] st);
		out_item_t r;
		r.out_byte = b;
		r.out_last = l;
		r.status   = st;
		return r;
	endfunction

	// b8 = even parity over the byte, b9 = its complement
	function automatic logic [9:0] add_parity(logic [7:0] b);
		logic p;
		p = ^b;
		return {!p, p, b};
	endfunction

	function automatic logic [9:0] word_bits(logic [9:0] w);
		return is_ten ? w : add_parity(w[7:0]);
	endfunction

	// MSB-first bit packer; every full byte becomes one stream result
	function automatic void pack_bits(logic [11:0] v, int n);
		logic [31:0] top;
		obuf = (obuf << n) | ({20'd0, v} & ((32'd1 << n) - 1));
		ocnt += n;
		while (ocnt >= 8) begin
			ocnt -= 8;
			top = obuf >> ocnt;
			step_bytes.push_back(mk_result(top[7:0], 1'b0, STAT_OK));
			obuf &= (32'd1 << ocnt) - 1;
		end
	endfunction

	// checksum word, ones padding, mark the final byte
	function automatic void close_packet();
		logic [9:0] ck;
		int pad;
		ck = is_ten ? {1'b0, csum} : add_parity(csum[7:0]);
		pack_bits({2'b00, ck}, 10);
		if (ocnt > 0) begin
			pad = 8 - ocnt;
			pack_bits((12'd1 << pad) - 12'd1, pad);
		end
		step_bytes[step_bytes.size() - 1].out_last = 1'b1;
		ph = P_DONE;
	endfunction

	function automatic void store_header(logic [9:0] w);
		case (hdr_idx)
			2'd0: did_w = w;
			2'd1: sdid_w = w;
			default: cnt_w = w;
		endcase
		hdr_idx++;
	endfunction

	// DID/SDID/count complete: either reject on count or start the stream
	function automatic void open_stream();
		if (int'(samples_q) < int'(cnt_w) + 3) begin
			step_bytes.push_back(mk_result(8'h00, 1'b1, STAT_COUNT_BIG));
			ph = P_DONE;
			return;
		end
		pack_bits({11'd0, chroma}, 7);
		pack_bits({1'b0, line_q}, 11);
		pack_bits(HORIZ_OFFSET, 12);
		pack_bits({2'b00, word_bits(did_w)}, 10);
		pack_bits({2'b00, word_bits(sdid_w)}, 10);
		pack_bits({2'b00, word_bits(cnt_w)}, 10);
		csum     = did_w[8:0] + sdid_w[8:0] + cnt_w[8:0];
		words_in = '0;
		grp      = '0;
		if (cnt_w == 0)
			close_packet();
		else
			ph = P_DATA;
	endfunction

	function automatic void take_word(logic [9:0] w);
		csum = csum + w[8:0];
		pack_bits({2'b00, word_bits(w)}, 10);
		words_in++;
		if (words_in >= cnt_w)
			close_packet();
	endfunction

	// one accepted request -> step_bytes
	function automatic void advance_converter(in_item_t req);
		bit skip;
		int need;
		logic [31:0] v;
		step_bytes.delete();
		if (req.first_byte) begin
			line_q    = req.line_number;
			samples_q = req.sample_count;
			is_ten    = (req.sample_coding == CODING_7 || req.sample_coding == CODING_8 ||
				req.sample_coding == CODING_9);
			chroma    = (req.sample_coding == CODING_5 || req.sample_coding == CODING_8 ||
				req.sample_coding == CODING_11);
			ibuf = '0; icnt = 0; hdr_idx = '0;
			did_w = '0; sdid_w = '0; cnt_w = '0; words_in = '0;
			grp = '0; csum = '0; obuf = '0; ocnt = 0;
			ph = P_HEADER;
		end
		if (ph == P_HEADER || ph == P_DATA) begin
			if (is_ten) begin
				ibuf = (ibuf << 8) | {24'd0, req.data_byte};
				icnt += 8;
				while (ph == P_HEADER || ph == P_DATA) begin
					// 2 skip bits after the count word and after every third user word
					skip = (ph == P_HEADER) ? (hdr_idx == 2'd3) : (grp == 2'd3);
					need = skip ? 2 : 10;
					if (icnt < need)
						break;
					icnt -= need;
					v = (ibuf >> icnt) & ((32'd1 << need) - 1);
					ibuf &= (32'd1 << icnt) - 1;
					if (ph == P_HEADER) begin
						if (skip)
							open_stream();
						else
							store_header(v[9:0]);
					end else if (skip) begin
						grp = '0;
					end else begin
						grp = (grp == 2'd2) ? 2'd3 : grp + 2'd1;
						take_word(v[9:0]);
					end
				end
			end else if (ph == P_HEADER) begin
				store_header({2'b00, req.data_byte});
				if (hdr_idx == 2'd3)
					open_stream();
			end else begin
				take_word({2'b00, req.data_byte});
			end
			if (req.last_byte) begin
				if (ph == P_HEADER) begin
					step_bytes.push_back(mk_result(8'h00, 1'b1, STAT_HDR_SHORT));
					ph = P_DONE;
				end else if (ph == P_DATA) begin
					step_bytes.push_back(mk_result(8'h00, 1'b1, STAT_TRUNC));
					ph = P_DONE;
				end
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------

	// present one request, wait for the handshake, then update the predictor
	task automatic offer(in_item_t req);
		if (!calm && $urandom_range(0, 5) == 0) begin
			anc_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		anc_ch.valid <= 1'b1;
		anc_ch.data  <= req;
		do @(posedge clk); while (!anc_ch.ready);
		requests_sent++;
		if (req.first_byte) begin
			packets++;
			if (req.sample_coding inside {CODING_7, CODING_8, CODING_9})
				ten_packets++;
		end
		advance_converter(req);
	endtask

	task automatic send_checked(in_item_t req);
		offer(req);
		foreach (step_bytes[k])
			pending_st2038.push_back(step_bytes[k]);
	endtask

	function automatic void append_bits(logic [9:0] v, int n);
		for (int k = n - 1; k >= 0; k--)
			stream_bits.push_back(v[k]);
	endfunction

	function automatic in_item_t random_req();
		in_item_t r;
		r.data_byte     = $urandom_range(0, 255);
		r.first_byte    = 1'b0;
		r.last_byte     = $urandom_range(0, 1);
		r.line_number   = $urandom_range(0, 2047);
		r.sample_count  = $urandom_range(0, 65535);
		r.sample_coding = $urandom_range(0, 255);
		return r;
	endfunction

	// One packet of random content. Kinds 0-5 are well formed, 6 is cut short with last,
	// 7 is cut short without last (next packet restarts it), 8 has count > samples - 3,
	// 9 is a few stray bytes with no packet start.
	task automatic send_packet();
		int kind, cnt, n;
		logic [7:0] coding, b;
		logic [9:0] cword;
		logic [15:0] samples;
		bit ten;
		logic [7:0] body [$];
		in_item_t req;

		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(1, 3))
				send_checked(random_req());
			return;
		end
		case ($urandom_range(0, 5))
			0: coding = CODING_7;
			1: coding = CODING_8;
			2: coding = CODING_9;
			3: coding = CODING_5;
			4: coding = CODING_11;
			default: coding = $urandom_range(0, 255);
		endcase
		ten = coding inside {CODING_7, CODING_8, CODING_9};

		if (kind == 8) begin
			cnt     = 0;
			cword   = ten ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 255));
			samples = $urandom_range(0, int'(cword) + 2);
		end else begin
			cnt     = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			cword   = cnt;
			samples = ($urandom_range(0, 3) == 0) ? cnt + 3 : $urandom_range(cnt + 3, 65535);
		end

		if (ten) begin
			stream_bits.delete();
			append_bits($urandom_range(0, 1023), 10);
			append_bits($urandom_range(0, 1023), 10);
			append_bits(cword, 10);
			append_bits($urandom_range(0, 3), 2);
			for (int i = 0; i < cnt; i++) begin
				if (i > 0 && i % 3 == 0)
					append_bits($urandom_range(0, 3), 2);
				append_bits($urandom_range(0, 1023), 10);
			end
			while (stream_bits.size() % 8 != 0)
				stream_bits.push_back($urandom_range(0, 1));
			for (int i = 0; i < stream_bits.size(); i += 8) begin
				for (int j = 0; j < 8; j++)
					b = {b[6:0], stream_bits[i + j]};
				body.push_back(b);
			end
		end else begin
			body.push_back($urandom_range(0, 255));
			body.push_back($urandom_range(0, 255));
			body.push_back(cword[7:0]);
			repeat (cnt) body.push_back($urandom_range(0, 255));
		end
		if (kind == 8)
			repeat ($urandom_range(1, 2)) body.push_back($urandom_range(0, 255));

		n = body.size();
		if (kind == 6 || kind == 7)
			n = $urandom_range(1, n - 1);
		for (int i = 0; i < n; i++) begin
			req = random_req();
			req.data_byte  = body[i];
			req.first_byte = (i == 0);
			req.last_byte  = (kind != 7) && (i == n - 1);
			if (i == 0) begin
				req.line_number   = $urandom_range(0, 2047);
				req.sample_count  = samples;
				req.sample_coding = coding;
			end
			send_checked(req);
		end
	endtask

	function automatic row_t drow(logic [7:0] d, bit f, bit l, logic [10:0] ln,
			logic [15:0] sc, logic [7:0] cd, row_check_t chk, logic [1:0] st);
		row_t r;
		r.req.data_byte     = d;
		r.req.first_byte    = f;
		r.req.last_byte     = l;
		r.req.line_number   = ln;
		r.req.sample_count  = sc;
		r.req.sample_coding = cd;
		r.check             = chk;
		r.status            = st;
		return r;
	endfunction

	initial begin : source_side
		row_t plan [$];
		bit paused;

		anc_ch.valid <= 1'b0;
		anc_ch.data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows. Error rows carry their result by hand; stream rows use the predictor.
		// byte before any packet start: ignored
		plan.push_back(drow(8'hFF, 1, 0, 0, 0, 0, NO_RESULT, STAT_OK));
		plan[0].req.first_byte = 1'b0;
		plan[0].req.last_byte  = 1'b1;
		// single-byte packet in 8-bit mode: header short
		plan.push_back(drow(8'h00, 1, 1, 0, 0, 0, ERROR_RESULT, STAT_HDR_SHORT));
		// coding 255, samples 3, count 1: count too big, then a stray byte after the end
		plan.push_back(drow(8'h00, 1, 0, 11'h7FF, 16'd3, 8'hFF, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'hFF, 0, 0, 0, 0, 0, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'h01, 0, 0, 0, 0, 0, ERROR_RESULT, STAT_COUNT_BIG));
		plan.push_back(drow(8'h55, 0, 1, 0, 0, 0, NO_RESULT, STAT_OK));
		// chroma 8-bit, line 2047, samples max, count 0: header + checksum only
		plan.push_back(drow(8'hFF, 1, 0, 11'h7FF, 16'hFFFF, CODING_5, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'h00, 0, 0, 0, 0, 0, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'h00, 0, 0, 0, 0, 0, BY_PREDICTOR, STAT_OK));
		// coding 11, samples exactly count + 3, truncated after two of three words
		plan.push_back(drow(8'h12, 1, 0, 11'h400, 16'd6, CODING_11, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'h34, 0, 0, 0, 0, 0, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'h03, 0, 0, 0, 0, 0, BY_PREDICTOR, STAT_OK));
		plan.push_back(drow(8'hAA, 0, 0, 0, 0, 0, BY_PREDICTOR, STAT_OK));
		plan.push_back(drow(8'h55, 0, 1, 0, 0, 0, BY_PREDICTOR, STAT_OK));
		// 10-bit: DID 0x3FF, SDID 0, count 2, skip bits 11, two user words
		plan.push_back(drow(8'hFF, 1, 0, 11'h555, 16'hFFFF, CODING_7, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'hC0, 0, 0, 0, 0, 0, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'h00, 0, 0, 0, 0, 0, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'h0B, 0, 0, 0, 0, 0, BY_PREDICTOR, STAT_OK));
		plan.push_back(drow(8'hA5, 0, 0, 0, 0, 0, BY_PREDICTOR, STAT_OK));
		plan.push_back(drow(8'h5A, 0, 0, 0, 0, 0, BY_PREDICTOR, STAT_OK));
		plan.push_back(drow(8'hFF, 0, 1, 0, 0, 0, BY_PREDICTOR, STAT_OK));
		// 10-bit packet dropped by a restart, the new one ends inside the header
		plan.push_back(drow(8'h00, 1, 0, 11'd1, 16'd100, CODING_8, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'h00, 1, 0, 11'd2, 16'h0010, CODING_9, NO_RESULT, STAT_OK));
		plan.push_back(drow(8'h40, 0, 1, 0, 0, 0, ERROR_RESULT, STAT_HDR_SHORT));

		foreach (plan[i]) begin
			if (plan[i].check == BY_PREDICTOR) begin
				send_checked(plan[i].req);
			end else begin
				offer(plan[i].req);
				if (plan[i].check == ERROR_RESULT)
					pending_st2038.push_back(mk_result(8'h00, 1'b1, plan[i].status));
			end
		end

		// random part: long sink stall first, a full drain halfway, no idling at the end
		long_hold_due = 1'b1;
		while (requests_sent < plan.size() + RANDOM_REQS) begin
			if (!paused && requests_sent >= plan.size() + RANDOM_REQS / 2) begin
				paused = 1'b1;
				anc_ch.valid <= 1'b0;
				do @(posedge clk); while (pending_st2038.size() != 0);
			end
			if (requests_sent >= plan.size() + RANDOM_REQS - 50)
				calm = 1'b1;
			send_packet();
		end

		anc_ch.valid <= 1'b0;
		while (pending_st2038.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests, %0d packet starts (%0d in 10-bit mode)",
			requests_sent, packets, ten_packets);
		$display("checked %0d stream bytes; errors short/count/trunc: %0d/%0d/%0d; mismatches %0d",
			bytes_ok, err_seen[STAT_HDR_SHORT], err_seen[STAT_COUNT_BIG], err_seen[STAT_TRUNC],
			errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result side: sink stalls and the byte checker
	// ---------------------------------------------------------------
	initial begin : sink_side
		st_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_due) begin
				// hold off long enough that the block must stop taking requests
				long_hold_due = 1'b0;
				st_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				st_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				st_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				st_ch.ready <= 1'b1;
			end else begin
				st_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want, got;
		if (arst_n && st_ch.valid && st_ch.ready) begin
			got = st_ch.data;
			if (pending_st2038.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected byte %h last %b status %0d",
						$realtime, got.out_byte, got.out_last, got.status);
			end else begin
				want = pending_st2038.pop_front();
				if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
						got.status !== want.status) begin
					errors++;
					if (errors <= 10)
						$display("%0t: byte exp %h/%b/%0d got %h/%b/%0d (byte/last/status)",
							$realtime, want.out_byte, want.out_last, want.status,
							got.out_byte, got.out_last, got.status);
				end else if (want.status == STAT_OK) begin
					bytes_ok++;
				end else begin
					err_seen[want.status]++;
				end
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#2_000_000;
		$display("timeout with %0d bytes still expected", pending_st2038.size());
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/anc2038_pkg.sv
design/anc2038_chan_if.sv
design/anc2038_front.sv
design/anc2038_tokq.sv
design/anc2038_back.sv
design/anc_436_to_2038_converter.sv
test/testbench.sv
